// ----- rtl/rcpg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rcpg_pkg;

  // Default slice limits.
  localparam int MAX_ANGULAR_DEF = 8;
  localparam int MAX_AXIAL_DEF   = 8;

  // Configuration port.
  localparam int CFG_AW = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_ANGULAR = 2'd0;
  localparam logic [1:0] REG_AXIAL   = 2'd1;
  localparam logic [1:0] REG_LIMIT   = 2'd2;

  localparam logic [3:0]  ANGULAR_RESET = 4'd4;
  localparam logic [3:0]  AXIAL_RESET   = 4'd3;
  localparam logic [15:0] LIMIT_RESET   = 16'hFFFF;

  // Datapath widths.
  localparam int DIV_W   = 21;
  localparam int DEN_W   = 5;
  localparam int DCNT_W  = 5;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 66;
  localparam int ACC_W   = 36;
  localparam int TRIG_W  = 17;
  localparam int COORD_W = 17;

  localparam logic [63:0] ONE_Q32     = 64'd4294967296;
  localparam logic [18:0] TURN_TO_Q32 = 19'd411775;
  localparam logic [14:0] QUARTER     = 15'd16384;
  localparam logic [13:0] EIGHTH      = 14'd8192;

  // Series terms after the leading ones (x for sine, 1 - x^2/2 for cosine): x^3/6,
  // x^5/120, x^7/5040 for sine and x^4/24, x^6/720, x^8/40320 for cosine.
  localparam int         NUM_TERMS = 6;
  localparam logic [2:0] LAST_TERM = 3'(NUM_TERMS - 1);

  localparam logic [31:0] RECIP_6     = 32'(ONE_Q32 / 6);
  localparam logic [31:0] RECIP_120   = 32'(ONE_Q32 / 120);
  localparam logic [31:0] RECIP_5040  = 32'(ONE_Q32 / 5040);
  localparam logic [31:0] RECIP_24    = 32'(ONE_Q32 / 24);
  localparam logic [31:0] RECIP_720   = 32'(ONE_Q32 / 720);
  localparam logic [31:0] RECIP_40320 = 32'(ONE_Q32 / 40320);

  function automatic logic [31:0] term_recip(input logic [2:0] k);
    logic [31:0] m;
    case (k)
      3'd0:    m = RECIP_6;
      3'd1:    m = RECIP_120;
      3'd2:    m = RECIP_5040;
      3'd3:    m = RECIP_24;
      3'd4:    m = RECIP_720;
      3'd5:    m = RECIP_40320;
      default: m = RECIP_40320;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] term_div(input logic [2:0] k);
    logic [15:0] d;
    case (k)
      3'd0:    d = 16'd6;
      3'd1:    d = 16'd120;
      3'd2:    d = 16'd5040;
      3'd3:    d = 16'd24;
      3'd4:    d = 16'd720;
      3'd5:    d = 16'd40320;
      default: d = 16'd40320;
    endcase
    return d;
  endfunction

  // Terms that are subtracted from their sum.
  function automatic logic term_sub(input logic [2:0] k);
    return (k == 3'd0) || (k == 3'd2) || (k == 3'd4);
  endfunction

  // Terms that belong to the cosine sum.
  function automatic logic term_cos(input logic [2:0] k);
    return (k == 3'd3) || (k == 3'd4) || (k == 3'd5);
  endfunction

  typedef enum logic [4:0] {
    S_IDLE,
    S_AX_START,
    S_AN_START,
    S_DIV,
    S_DIV_END,
    S_SC_X,
    S_SC_P2,
    S_SC_P3,
    S_SC_P4,
    S_SC_P5,
    S_SC_P6,
    S_SC_P7,
    S_SC_P8,
    S_SC_P9,
    S_DV_Q,
    S_DV_R,
    S_DV_C,
    S_SC_END,
    S_PT_X,
    S_PT_T,
    S_PT_Y,
    S_PT_Z,
    S_PT_DONE,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/range_cone_point_generator.sv -----
// Channel   Handshake                Payload
// config    psel/penable/pwrite      paddr, pwdata, prdata (APB-style, pready tied high)
// in        in_valid / in_stall      distance, lower_bound, upper_bound, cone_width
// out       out_valid / out_stall    point_x, point_y, point_z, last_point
//
// A rejected reading is dropped without raising in_stall. The work per point is paced by
// the one-bit-per-cycle restoring divider for the slice angles and by the single shared
// 33x33 multiplier that evaluates the sine and cosine series and the coordinate products.
// Reset is synchronous and restores the register defaults. in_stall is high from the
// accepted transfer until the last point has been transferred out; out_stall simply
// holds the current point.
`timescale 1ns / 1ps
`default_nettype none

module range_cone_point_generator
  import rcpg_pkg::*;
#(
  parameter int MAX_ANGULAR = MAX_ANGULAR_DEF,
  parameter int MAX_AXIAL   = MAX_AXIAL_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [CFG_AW-1:0]         paddr,
  input  wire logic [DATA_W-1:0]         pwdata,
  output logic      [DATA_W-1:0]         prdata,
  output logic                           pready,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [15:0]               distance,
  input  wire logic [15:0]               lower_bound,
  input  wire logic [15:0]               upper_bound,
  input  wire logic [15:0]               cone_width,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [COORD_W-1:0]      point_x,
  output logic signed [COORD_W-1:0]      point_y,
  output logic signed [COORD_W-1:0]      point_z,
  output logic                           last_point
);

  localparam int AN_W = $clog2(MAX_ANGULAR + 1);
  localparam int AX_W = $clog2(MAX_AXIAL + 1);

  // Configuration registers.
  logic [3:0]  angular_count;
  logic [3:0]  axial_count;
  logic [15:0] range_limit;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      angular_count <= ANGULAR_RESET;
      axial_count   <= AXIAL_RESET;
      range_limit   <= LIMIT_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ANGULAR: angular_count <= pwdata[3:0];
        REG_AXIAL:   axial_count   <= pwdata[3:0];
        REG_LIMIT:   range_limit   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ANGULAR: prdata = DATA_W'(angular_count);
      REG_AXIAL:   prdata = DATA_W'(axial_count);
      REG_LIMIT:   prdata = DATA_W'(range_limit);
      default:     prdata = '0;
    endcase
  end

  // Slice counts, with zero read as one and large values saturated.
  logic [3:0] na_clamp;
  logic [3:0] nx_clamp;

  always_comb begin
    if (angular_count == 4'd0) begin
      na_clamp = 4'd1;
    end else if (angular_count > 4'(MAX_ANGULAR)) begin
      na_clamp = 4'(MAX_ANGULAR);
    end else begin
      na_clamp = angular_count;
    end
    if (axial_count == 4'd0) begin
      nx_clamp = 4'd1;
    end else if (axial_count > 4'(MAX_AXIAL)) begin
      nx_clamp = 4'(MAX_AXIAL);
    end else begin
      nx_clamp = axial_count;
    end
  end

  state_t state;
  state_t state_next;

  logic in_acc;
  logic reject;

  assign in_acc = in_valid && !in_stall;
  assign reject = (distance < lower_bound) || (distance > upper_bound) ||
                  (distance > range_limit);

  // Item registers.
  logic [15:0]     r;
  logic [15:0]     fov;
  logic [AN_W-1:0] na_m1;
  logic [AX_W-1:0] nx_m1;
  logic [AN_W-1:0] j;
  logic [AX_W-1:0] i;
  logic            phase_ax;

  // Angle divider.
  logic [DIV_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic [DEN_W-1:0]  div_rem;
  logic [DCNT_W-1:0] div_cnt;
  logic              ang_neg;
  logic [DEN_W:0]    div_trial;
  logic              div_ge;

  assign div_trial = {div_rem, div_num[DIV_W-1]};
  assign div_ge    = div_trial >= {1'b0, div_den};

  // Slice setup values.
  logic [DIV_W-1:0] ax_num;
  logic [DEN_W-1:0] ax_den;
  logic [DIV_W-1:0] an_num;
  logic [DEN_W-1:0] an_den;
  logic             an_neg;
  logic             an_skip;
  logic [19:0]      fov_k;

  always_comb begin
    int k_int;
    logic [3:0] k_mag;
    k_int   = 2 * int'(j) - int'(na_m1);
    an_neg  = k_int < 0;
    k_mag   = 4'(an_neg ? -k_int : k_int);
    fov_k   = 20'(fov) * 20'(k_mag);
    an_num  = DIV_W'({fov_k, 1'b0}) + (DIV_W'(na_m1) << 1);
    an_den  = DEN_W'(DEN_W'(na_m1) << 2);
    ax_num  = (DIV_W'(i) << 16) + DIV_W'(nx_m1) + DIV_W'(1);
    ax_den  = DEN_W'((DEN_W'(nx_m1) + DEN_W'(1)) << 1);
    // With an odd slice count the center point is only emitted on the first rotation.
    an_skip = !na_m1[0] && (j == (na_m1 >> 1)) && (i != '0);
  end

  // Sine/cosine datapath.
  logic [15:0]       ang;
  logic [13:0]       ang_low;
  logic              swap;
  logic [14:0]       t;
  logic [PROD_W-1:0] prod;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [31:0]       xr, x2, x3, x4, x5, x6, x7, x8;
  logic [31:0]       q0;
  logic [2:0]        term;
  logic [31:0]       term_n;
  logic [32:0]       term_rem;
  logic [32:0]       term_q;
  logic signed [ACC_W-1:0] term_ext;
  logic signed [ACC_W-1:0] sin_acc;
  logic signed [ACC_W-1:0] cos_acc;

  assign ang_low = ang[13:0];
  assign swap    = ang_low > EIGHTH;
  assign t       = swap ? (QUARTER - {1'b0, ang_low}) : {1'b0, ang_low};

  always_comb begin
    case (term)
      3'd0:    term_n = x3;
      3'd1:    term_n = x5;
      3'd2:    term_n = x7;
      3'd3:    term_n = x4;
      3'd4:    term_n = x6;
      3'd5:    term_n = x8;
      default: term_n = '0;
    endcase
  end

  // The reciprocal product is at most one low; one compare fixes it.
  assign term_rem = {1'b0, term_n} - prod[32:0];
  assign term_q   = {1'b0, q0} + ((term_rem >= 33'(term_div(term))) ? 33'd1 : 33'd0);
  assign term_ext = $signed({3'b000, term_q});

  // Final rounding and octant mapping.
  logic [ACC_W-1:0]  sin_sum;
  logic [ACC_W-1:0]  cos_sum;
  logic [TRIG_W-1:0] sin_poly;
  logic [TRIG_W-1:0] cos_poly;
  logic [TRIG_W-1:0] ps, pc;
  logic [TRIG_W-1:0] s_mag, c_mag;
  logic              s_neg, c_neg;

  always_comb begin
    sin_sum  = (sin_acc < 0) ? ACC_W'(32768) : ACC_W'(sin_acc) + ACC_W'(32768);
    cos_sum  = (cos_acc < 0) ? ACC_W'(32768) : ACC_W'(cos_acc) + ACC_W'(32768);
    sin_poly = sin_sum[32:16];
    cos_poly = cos_sum[32:16];
    ps       = swap ? cos_poly : sin_poly;
    pc       = swap ? sin_poly : cos_poly;
    case (ang[15:14])
      2'd0: begin
        s_mag = ps; s_neg = 1'b0; c_mag = pc; c_neg = 1'b0;
      end
      2'd1: begin
        s_mag = pc; s_neg = 1'b0; c_mag = ps; c_neg = 1'b1;
      end
      2'd2: begin
        s_mag = ps; s_neg = 1'b1; c_mag = pc; c_neg = 1'b1;
      end
      default: begin
        s_mag = pc; s_neg = 1'b1; c_mag = ps; c_neg = 1'b0;
      end
    endcase
  end

  // Point datapath.
  logic [TRIG_W-1:0]  sa_mag, ca_mag, sb_mag, cb_mag;
  logic               sa_neg, ca_neg, sb_neg, cb_neg;
  logic [32:0]        rs;
  logic [COORD_W-1:0] xm, ym;
  logic [PROD_W-1:0]  rnd16;
  logic [PROD_W-1:0]  rnd32;

  assign rnd16 = prod + PROD_W'(32768);
  assign rnd32 = prod + PROD_W'(32'h8000_0000);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    in_stall   = state != S_IDLE;
    out_valid  = state == S_EMIT;
    case (state)
      S_IDLE: begin
        if (in_acc && !reject) begin
          state_next = (na_clamp == 4'd1) ? S_EMIT : S_AX_START;
        end
      end
      S_AX_START: state_next = S_DIV;
      S_AN_START: begin
        if (!an_skip) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt == '0) begin
          state_next = S_DIV_END;
        end
      end
      S_DIV_END: state_next = S_SC_X;
      S_SC_X: begin
        mul_a      = MUL_W'(t);
        mul_b      = MUL_W'(TURN_TO_Q32);
        state_next = S_SC_P2;
      end
      S_SC_P2: begin
        mul_a      = MUL_W'(prod[31:0]);
        mul_b      = MUL_W'(prod[31:0]);
        state_next = S_SC_P3;
      end
      S_SC_P3: begin
        mul_a      = MUL_W'(prod[63:32]);
        mul_b      = MUL_W'(xr);
        state_next = S_SC_P4;
      end
      S_SC_P4: begin
        mul_a      = MUL_W'(x2);
        mul_b      = MUL_W'(x2);
        state_next = S_SC_P5;
      end
      S_SC_P5: begin
        mul_a      = MUL_W'(x3);
        mul_b      = MUL_W'(x2);
        state_next = S_SC_P6;
      end
      S_SC_P6: begin
        mul_a      = MUL_W'(x4);
        mul_b      = MUL_W'(x2);
        state_next = S_SC_P7;
      end
      S_SC_P7: begin
        mul_a      = MUL_W'(x5);
        mul_b      = MUL_W'(x2);
        state_next = S_SC_P8;
      end
      S_SC_P8: begin
        mul_a      = MUL_W'(x4);
        mul_b      = MUL_W'(x4);
        state_next = S_SC_P9;
      end
      S_SC_P9: state_next = S_DV_Q;
      S_DV_Q: begin
        mul_a      = MUL_W'(term_n);
        mul_b      = MUL_W'(term_recip(term));
        state_next = S_DV_R;
      end
      S_DV_R: begin
        mul_a      = MUL_W'(prod[63:32]);
        mul_b      = MUL_W'(term_div(term));
        state_next = S_DV_C;
      end
      S_DV_C: state_next = (term == LAST_TERM) ? S_SC_END : S_DV_Q;
      S_SC_END: state_next = phase_ax ? S_AN_START : S_PT_X;
      S_PT_X: begin
        mul_a      = MUL_W'(r);
        mul_b      = MUL_W'(ca_mag);
        state_next = S_PT_T;
      end
      S_PT_T: begin
        mul_a      = MUL_W'(r);
        mul_b      = MUL_W'(sa_mag);
        state_next = S_PT_Y;
      end
      S_PT_Y: begin
        mul_a      = prod[32:0];
        mul_b      = MUL_W'(cb_mag);
        state_next = S_PT_Z;
      end
      S_PT_Z: begin
        mul_a      = rs;
        mul_b      = MUL_W'(sb_mag);
        state_next = S_PT_DONE;
      end
      S_PT_DONE: state_next = S_EMIT;
      S_EMIT: begin
        if (!out_stall) begin
          if (last_point) begin
            state_next = S_IDLE;
          end else if (j == na_m1) begin
            state_next = S_AX_START;
          end else begin
            state_next = S_AN_START;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        r     <= distance;
        fov   <= cone_width;
        na_m1 <= AN_W'(na_clamp - 4'd1);
        nx_m1 <= AX_W'(nx_clamp - 4'd1);
        i     <= '0;
        j     <= '0;
        // A single-slice cloud is the bare range along the axis.
        point_x    <= $signed({1'b0, distance});
        point_y    <= '0;
        point_z    <= '0;
        last_point <= 1'b1;
      end
      S_AX_START: begin
        div_num  <= ax_num;
        div_den  <= ax_den;
        div_rem  <= '0;
        div_cnt  <= DCNT_W'(DIV_W - 1);
        ang_neg  <= 1'b0;
        phase_ax <= 1'b1;
      end
      S_AN_START: begin
        if (an_skip) begin
          j <= j + AN_W'(1);
        end
        div_num  <= an_num;
        div_den  <= an_den;
        div_rem  <= '0;
        div_cnt  <= DCNT_W'(DIV_W - 1);
        ang_neg  <= an_neg;
        phase_ax <= 1'b0;
      end
      S_DIV: begin
        div_rem <= div_ge ? DEN_W'(div_trial - {1'b0, div_den}) : DEN_W'(div_trial);
        div_num <= {div_num[DIV_W-2:0], div_ge};
        div_cnt <= div_cnt - DCNT_W'(1);
      end
      S_DIV_END: begin
        ang <= ang_neg ? (16'd0 - div_num[15:0]) : div_num[15:0];
      end
      S_SC_P2: xr <= prod[31:0];
      S_SC_P3: x2 <= prod[63:32];
      S_SC_P4: x3 <= prod[63:32];
      S_SC_P5: x4 <= prod[63:32];
      S_SC_P6: x5 <= prod[63:32];
      S_SC_P7: x6 <= prod[63:32];
      S_SC_P8: x7 <= prod[63:32];
      S_SC_P9: begin
        x8      <= prod[63:32];
        sin_acc <= $signed(ACC_W'(xr));
        cos_acc <= $signed(ACC_W'(ONE_Q32)) - $signed(ACC_W'(x2 >> 1));
        term    <= '0;
      end
      S_DV_R: q0 <= prod[63:32];
      S_DV_C: begin
        if (term_cos(term)) begin
          cos_acc <= term_sub(term) ? cos_acc - term_ext : cos_acc + term_ext;
        end else begin
          sin_acc <= term_sub(term) ? sin_acc - term_ext : sin_acc + term_ext;
        end
        term <= term + 3'd1;
      end
      S_SC_END: begin
        if (phase_ax) begin
          sb_mag <= s_mag;
          sb_neg <= s_neg;
          cb_mag <= c_mag;
          cb_neg <= c_neg;
        end else begin
          sa_mag <= s_mag;
          sa_neg <= s_neg;
          ca_mag <= c_mag;
          ca_neg <= c_neg;
        end
      end
      S_PT_T: xm <= rnd16[32:16];
      S_PT_Y: rs <= prod[32:0];
      S_PT_Z: ym <= rnd32[48:32];
      S_PT_DONE: begin
        point_x    <= ca_neg ? $signed(COORD_W'(0) - xm) : $signed(xm);
        point_y    <= (sa_neg ^ cb_neg) ? $signed(COORD_W'(0) - ym) : $signed(ym);
        point_z    <= (sa_neg ^ sb_neg) ? $signed(COORD_W'(0) - rnd32[48:32])
                                        : $signed(rnd32[48:32]);
        last_point <= (i == nx_m1) && (j == na_m1);
      end
      S_EMIT: begin
        if (!out_stall && !last_point) begin
          if (j == na_m1) begin
            j <= '0;
            i <= i + AX_W'(1);
          end else begin
            j <= j + AN_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb
  import rcpg_pkg::*;
();

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [16:0] x;
    logic [16:0] y;
    logic [16:0] z;
    logic        last;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] distance = '0, lower_bound = '0, upper_bound = '0, cone_width = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COORD_W-1:0] point_x, point_y, point_z;
  logic last_point;

  // Shadow copy of the configuration registers.
  logic [3:0]  cfg_angular;
  logic [3:0]  cfg_axial;
  logic [15:0] cfg_limit;

  point_t pending_points[$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     idle_en = 1'b1;
  int     stall_left = 0;

  range_cone_point_generator u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .distance(distance),
    .lower_bound(lower_bound), .upper_bound(upper_bound), .cone_width(cone_width),
    .out_valid(out_valid), .out_stall(out_stall), .point_x(point_x),
    .point_y(point_y), .point_z(point_z), .last_point(last_point)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (!idle_en || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= idle_len();
      out_stall <= 1'b0;
    end
  end

  function automatic longint series_sin(input longint unsigned t);
    longint unsigned x, x2, x3, x5, x7;
    longint v;
    x  = t * 64'd411775;
    x2 = (x * x) >> 32;
    x3 = (x2 * x) >> 32;
    x5 = (x3 * x2) >> 32;
    x7 = (x5 * x2) >> 32;
    v = longint'(x) - longint'(x3 / 6) + longint'(x5 / 120) - longint'(x7 / 5040);
    if (v < 0) v = 0;
    return longint'((unsigned'(v) + 32768) >> 16);
  endfunction

  function automatic longint series_cos(input longint unsigned t);
    longint unsigned x, x2, x4, x6, x8;
    longint v;
    x  = t * 64'd411775;
    x2 = (x * x) >> 32;
    x4 = (x2 * x2) >> 32;
    x6 = (x4 * x2) >> 32;
    x8 = (x4 * x4) >> 32;
    v = 64'sd4294967296 - longint'(x2 / 2) + longint'(x4 / 24)
        - longint'(x6 / 720) + longint'(x8 / 40320);
    if (v < 0) v = 0;
    return longint'((unsigned'(v) + 32768) >> 16);
  endfunction

  task automatic turn_sincos(input logic [15:0] ang, output longint s, output longint c);
    longint unsigned rem;
    longint ps, pc;
    rem = ang[13:0];
    if (rem <= 8192) begin
      ps = series_sin(rem);
      pc = series_cos(rem);
    end else begin
      ps = series_cos(16384 - rem);
      pc = series_sin(16384 - rem);
    end
    case (ang[15:14])
      2'd0: begin s = ps;  c = pc;  end
      2'd1: begin s = pc;  c = -ps; end
      2'd2: begin s = -ps; c = -pc; end
      default: begin s = -pc; c = ps; end
    endcase
  endtask

  function automatic longint shift_round(input longint num, input int sh);
    longint unsigned mag, res;
    mag = (num < 0) ? unsigned'(-num) : unsigned'(num);
    res = (mag + (64'd1 << (sh - 1))) >> sh;
    return (num < 0) ? -longint'(res) : longint'(res);
  endfunction

  function automatic longint div_round(input longint num, input longint den);
    longint unsigned mag, res;
    mag = (num < 0) ? unsigned'(-num) : unsigned'(num);
    res = (mag * 2 + den) / (den * 2);
    return (num < 0) ? -longint'(res) : longint'(res);
  endfunction

  task automatic predict_cloud(input logic [15:0] r, lo, hi, fov);
    longint na, nx, axis, ang, sb, cb, sa, ca;
    point_t p;
    if (r < lo || r > hi || r > cfg_limit) return;
    na = (cfg_angular == 0) ? 1 : (cfg_angular > 8) ? 8 : cfg_angular;
    nx = (cfg_axial == 0) ? 1 : (cfg_axial > 8) ? 8 : cfg_axial;
    if (na == 1) begin
      p.x = {1'b0, r};
      p.y = '0;
      p.z = '0;
      p.last = 1'b1;
      pending_points.push_back(p);
      return;
    end
    for (longint i = 0; i < nx; i++) begin
      axis = div_round(i * 32768, nx);
      turn_sincos(axis[15:0], sb, cb);
      for (longint j = 0; j < na; j++) begin
        // With an odd count the center ray is shared by every axial slice.
        if (na[0] && j == na / 2 && i != 0) continue;
        ang = div_round(longint'(fov) * (2 * j - (na - 1)), 2 * (na - 1));
        turn_sincos(ang[15:0], sa, ca);
        p.x = 17'(shift_round(longint'(r) * ca, 16));
        p.y = 17'(shift_round(longint'(r) * sa * cb, 32));
        p.z = 17'(shift_round(longint'(r) * sa * sb, 32));
        p.last = 1'b0;
        pending_points.push_back(p);
      end
    end
    pending_points[pending_points.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    point_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point x=%h y=%h z=%h last=%b",
                   point_x, point_y, point_z, last_point);
      end else begin
        e = pending_points.pop_front();
        if (point_x !== e.x || point_y !== e.y || point_z !== e.z ||
            last_point !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: expected x=%h y=%h z=%h last=%b, got %h %h %h %b",
                     e.x, e.y, e.z, e.last, point_x, point_y, point_z, last_point);
        end
      end
    end
  end

  task automatic drain();
    while (pending_points.size() != 0) @(posedge clk);
    // A rejected reading may still be in flight.
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    // Keep the last reading from being taken a second time.
    in_valid <= 1'b0;
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= CFG_AW'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ANGULAR: cfg_angular = val[3:0];
      REG_AXIAL:   cfg_axial = val[3:0];
      REG_LIMIT:   cfg_limit = val[15:0];
      default: ;
    endcase
  endtask

  task automatic send_reading(input logic [15:0] r, lo, hi, fov);
    int gap;
    in_valid <= 1'b1;
    distance <= r;
    lower_bound <= lo;
    upper_bound <= hi;
    cone_width <= fov;
    do @(posedge clk); while (in_stall);
    predict_cloud(r, lo, hi, fov);
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) begin
        distance <= $urandom;
        cone_width <= $urandom;
        @(posedge clk);
      end
    end
  endtask

  task automatic test_defaults();
    send_reading(16'd1000, 16'd0, 16'hFFFF, 16'd4096);
    send_reading(16'd0, 16'd0, 16'd0, 16'd8192);
    send_reading(16'hFFFF, 16'd0, 16'hFFFF, 16'd32768);
    send_reading(16'd99, 16'd100, 16'd200, 16'd4096);
    send_reading(16'd201, 16'd100, 16'd200, 16'd4096);
    send_reading(16'd150, 16'd100, 16'd200, 16'd0);
  endtask

  task automatic test_single_point();
    write_reg(REG_ANGULAR, 32'd1);
    send_reading(16'd1234, 16'd0, 16'd5000, 16'd9000);
    write_reg(REG_ANGULAR, 32'd0);
    send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd100);
  endtask

  task automatic test_saturation();
    write_reg(REG_ANGULAR, 32'd15);
    write_reg(REG_AXIAL, 32'd15);
    send_reading(16'd50000, 16'd0, 16'hFFFF, 16'd20000);
    write_reg(REG_ANGULAR, 32'd3);
    write_reg(REG_AXIAL, 32'd0);
    send_reading(16'd777, 16'd0, 16'hFFFF, 16'd16384);
    write_reg(REG_AXIAL, 32'd8);
    send_reading(16'd65535, 16'd0, 16'hFFFF, 16'd12000);
  endtask

  task automatic test_range_limit();
    write_reg(REG_ANGULAR, 32'd2);
    write_reg(REG_AXIAL, 32'd1);
    write_reg(REG_LIMIT, 32'd0);
    send_reading(16'd0, 16'd0, 16'hFFFF, 16'd1000);
    send_reading(16'd1, 16'd0, 16'hFFFF, 16'd1000);
    write_reg(REG_LIMIT, 32'h0000FFFF);
    send_reading(16'hFFFF, 16'd0, 16'hFFFF, 16'd1000);
  endtask

  task automatic test_wide_fov();
    write_reg(REG_ANGULAR, 32'd5);
    write_reg(REG_AXIAL, 32'd2);
    send_reading(16'd30000, 16'd0, 16'hFFFF, 16'hFFFF);
    send_reading(16'd30000, 16'd0, 16'hFFFF, 16'd40000);
    send_reading(16'd30000, 16'd0, 16'hFFFF, 16'h5555);
  endtask

  task automatic test_unused_address();
    write_reg(REG_UNUSED, 32'hFFFFFFFF);
    send_reading(16'd4321, 16'd0, 16'hFFFF, 16'd6000);
  endtask

  task automatic test_random();
    logic [15:0] r, lo, hi;
    for (int phase = 0; phase < 8; phase++) begin
      idle_en = (phase % 3) != 1;
      // Keep most clouds small so the run stays short.
      if (phase == 3) begin
        write_reg(REG_ANGULAR, 32'd8);
        write_reg(REG_AXIAL, 32'd8);
      end else begin
        write_reg(REG_ANGULAR, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 4));
        write_reg(REG_AXIAL, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 3));
      end
      write_reg(REG_LIMIT, ($urandom_range(0, 2) == 0) ? $urandom : 32'hFFFF);
      for (int n = 0; n < 14; n++) begin
        r = $urandom;
        if ($urandom_range(0, 4) != 0) begin
          lo = $urandom_range(0, r);
          hi = $urandom_range(r, 65535);
        end else begin
          lo = $urandom;
          hi = $urandom;
        end
        send_reading(r, lo, hi, $urandom);
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    cfg_angular = ANGULAR_RESET;
    cfg_axial = AXIAL_RESET;
    cfg_limit = LIMIT_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_single_point();
    test_saturation();
    test_range_limit();
    test_wide_fov();
    test_unused_address();
    test_random();
    in_valid <= 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- range_cone_point_generator.f -----
rtl/rcpg_pkg.sv
rtl/range_cone_point_generator.sv
tb/tb.sv
